### rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  // Grid geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field widths.
  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

  // Depth of the command queue between front and back.
  localparam int FIFO_DEPTH = 2;

  localparam logic [CHAR_W-1:0] TEXT_COLOUR_RESET = 8'd15;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A       = 8'h41;

  // Opcodes of an input beat.
  localparam logic [OP_W-1:0] OP_WRITE_CHAR = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_HEX  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_POS    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd4;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_HEX,
    CMD_SETPOS,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_e;

  // Classified command as it travels through the queue.
  typedef struct packed {
    cmd_kind_e               kind;
    logic [CHAR_W-1:0]       ch0;
    logic [CHAR_W-1:0]       ch1;
    logic [CHAR_W-1:0]       colour;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
  } cmd_t;

  // Status of the execution side.
  typedef struct packed {
    logic busy;
    logic clearing;
  } back_status_t;

endpackage

### rtl/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tcw_front.sv
`timescale 1ns / 1ps

module tcw_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tcw_pkg::OP_W-1:0]    opcode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_colour_i,
  input  logic [tcw_pkg::COL_W-1:0]   pos_col_i,
  input  logic [tcw_pkg::ROW_W-1:0]   pos_row_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  text_colour_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output tcw_pkg::cmd_t               cmd_o
);

  import tcw_pkg::*;

  function automatic logic [CHAR_W-1:0] hex_digit(logic [3:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {4'b0000, nib};
    return (nib < 4'd10) ? (CH_ZERO + wide) : (CH_A + wide - 8'd10);
  endfunction

  logic  valid_q, valid_d;
  cmd_t  cmd_q, cmd_d;
  logic  in_fire;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Decode the opcode and clamp positions to the grid.
  always_comb begin
    cmd_d        = '0;
    cmd_d.kind   = CMD_NOP;
    cmd_d.ch0    = char_code_i;
    cmd_d.colour = char_colour_i;
    cmd_d.col    = (pos_col_i > COL_MAX) ? COL_MAX : pos_col_i;
    cmd_d.row    = (pos_row_i > ROW_MAX) ? ROW_MAX : pos_row_i;
    case (opcode_i)
      OP_WRITE_CHAR: cmd_d.kind = CMD_CHAR;
      OP_WRITE_HEX: begin
        cmd_d.kind   = CMD_HEX;
        cmd_d.ch0    = hex_digit(char_code_i[7:4]);
        cmd_d.ch1    = hex_digit(char_code_i[3:0]);
        cmd_d.colour = text_colour_i;
      end
      OP_SET_POS:   cmd_d.kind = CMD_SETPOS;
      OP_CLEAR:     cmd_d.kind = CMD_CLEAR;
      OP_READ_CELL: cmd_d.kind = CMD_READ;
      default:      cmd_d.kind = CMD_NOP;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

### rtl/tcw_fifo.sv
`timescale 1ns / 1ps

module tcw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tcw_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tcw_pkg::cmd_t pop_data_o
);

  import tcw_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  cmd_t             slot_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/tcw_back.sv
`timescale 1ns / 1ps

module tcw_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  tcw_pkg::cmd_t               cmd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcw_pkg::CHAR_W-1:0]  cell_char_o,
  output logic [tcw_pkg::CHAR_W-1:0]  cell_colour_o,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col_o,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row_o,
  output tcw_pkg::back_status_t       status_o
);

  import tcw_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HEX2  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELL_COUNT - 1);

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  logic [1:0]        state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CHAR_W-1:0] ch1_q, ch1_d;
  logic [CHAR_W-1:0] colour_q, colour_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic [CHAR_W-1:0] out_colour_q, out_colour_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;

  logic              out_free, take;
  logic [CHAR_W-1:0] wr_ch;
  logic              put_en;
  logic [COL_W-1:0]  adv_col;
  logic [ROW_W-1:0]  adv_row;
  logic [ROW_W-1:0]  inc_row;

  logic              char_we, colour_we;
  logic [ADDR_W-1:0] char_waddr, raddr;
  logic [CHAR_W-1:0] char_wdata;
  logic [CHAR_W-1:0] rd_char, rd_colour;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign take        = cmd_ready_o && cmd_valid_i;

  // Cursor after one character put: newline and column wrap both start a row.
  assign wr_ch   = (state_q == ST_HEX2) ? ch1_q : cmd_i.ch0;
  assign inc_row = (row_q == ROW_MAX) ? '0 : row_q + 1'b1;
  always_comb begin
    adv_col = col_q + 1'b1;
    adv_row = row_q;
    if (wr_ch == CH_NEWLINE || col_q == COL_MAX) begin
      adv_col = '0;
      adv_row = inc_row;
    end
  end

  assign raddr = cell_addr(cmd_i.row, cmd_i.col);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    ch1_d        = ch1_q;
    colour_d     = colour_q;
    clr_addr_d   = clr_addr_q;
    put_en       = 1'b0;
    char_we      = 1'b0;
    colour_we    = 1'b0;
    char_waddr   = cell_addr(row_q, col_q);
    char_wdata   = wr_ch;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_char_d   = out_char_q;
    out_colour_d = out_colour_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;

    case (state_q)
      ST_IDLE: begin
        colour_d = cmd_i.colour;
        if (take) begin
          case (cmd_i.kind)
            CMD_CHAR: begin
              put_en      = 1'b1;
              out_valid_d = 1'b1;
            end
            CMD_HEX: begin
              put_en  = 1'b1;
              ch1_d   = cmd_i.ch1;
              state_d = ST_HEX2;
            end
            CMD_SETPOS: begin
              col_d       = cmd_i.col;
              row_d       = cmd_i.row;
              out_valid_d = 1'b1;
            end
            CMD_CLEAR: begin
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
            end
            CMD_READ: begin
              state_d = ST_READ;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_HEX2: begin
        put_en      = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_CLEAR: begin
        char_we    = 1'b1;
        char_waddr = clr_addr_q;
        char_wdata = CH_SPACE;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_LAST) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A newline moves the cursor but stores nothing.
    if (put_en) begin
      char_we   = (wr_ch != CH_NEWLINE);
      colour_we = (wr_ch != CH_NEWLINE);
      col_d     = adv_col;
      row_d     = adv_row;
    end

    if (out_valid_d && !(out_valid_q && !out_ready_i)) begin
      out_col_d = col_d;
      out_row_d = row_d;
      if (state_q == ST_READ) begin
        out_char_d   = rd_char;
        out_colour_d = rd_colour;
      end else begin
        out_char_d   = '0;
        out_colour_d = '0;
      end
    end
  end

  tcw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CELL_COUNT)
  ) u_char_ram (
    .clk_i  (clk_i),
    .we_i   (char_we),
    .waddr_i(char_waddr),
    .wdata_i(char_wdata),
    .raddr_i(raddr),
    .rdata_o(rd_char)
  );

  tcw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CELL_COUNT)
  ) u_colour_ram (
    .clk_i  (clk_i),
    .we_i   (colour_we),
    .waddr_i(cell_addr(row_q, col_q)),
    .wdata_i(colour_d),
    .raddr_i(raddr),
    .rdata_o(rd_colour)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch1_q        <= ch1_d;
    colour_q     <= colour_d;
    clr_addr_q   <= clr_addr_d;
    out_char_q   <= out_char_d;
    out_colour_q <= out_colour_d;
    out_col_q    <= out_col_d;
    out_row_q    <= out_row_d;
  end

  assign out_valid_o       = out_valid_q;
  assign cell_char_o       = out_char_q;
  assign cell_colour_o     = out_colour_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_row_o      = out_row_q;
  assign status_o.busy     = (state_q != ST_IDLE);
  assign status_o.clearing = (state_q == ST_CLEAR);

endmodule

### rtl/text_console_writer_unit.sv
`timescale 1ns / 1ps

// Flow: each input beat is registered in the front end, passes the command queue and
// is executed by the back end, which answers every command with a registered result
// beat. A hex write makes two memory writes, a cell read uses a registered memory read
// and a clear writes a space to every cell; a new command waits for an idle back end.
// Reset: cursor to row 0 column 0, text colour to 15, queues empty; the cell
// memories are not cleared and hold unknown data until written.
module text_console_writer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input beats. tdata, from bit 0 up: opcode[2:0], char_code[10:3],
  // char_colour[18:11], pos_col[25:19], pos_row[30:26], zero pad[31].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,

  // Result beats. tdata, from bit 0 up: cell_char[7:0], cell_colour[15:8],
  // cursor_col[22:16], cursor_row[27:23], zero pad[31:28].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,

  // Text colour register, used by hex writes.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  import tcw_pkg::*;

  logic [CHAR_W-1:0] text_colour_q;

  logic              front_valid;
  cmd_t              front_cmd;
  logic              fifo_ready;
  logic              fifo_valid;
  cmd_t              fifo_cmd;
  logic              back_ready;
  back_status_t      back_status;

  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_colour;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;

  // The user must write the register only while the block is idle; the block itself
  // does not enforce this, so the front end may sample it when it classifies a hex write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_colour_q <= TEXT_COLOUR_RESET;
    end else if (cfg_we_i) begin
      text_colour_q <= cfg_wdata_i;
    end
  end

  // Front end: decodes the opcode, clamps positions and expands a hex byte
  // into its two digit characters.
  tcw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .opcode_i     (s_axis_tdata[2:0]),
    .char_code_i  (s_axis_tdata[10:3]),
    .char_colour_i(s_axis_tdata[18:11]),
    .pos_col_i    (s_axis_tdata[25:19]),
    .pos_row_i    (s_axis_tdata[30:26]),
    .text_colour_i(text_colour_q),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (fifo_ready),
    .cmd_o        (front_cmd)
  );

  // Short command queue so that the front end keeps accepting beats while
  // the back end is busy with a multi-cycle command.
  tcw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(fifo_ready),
    .push_data_i (front_cmd),
    .pop_valid_o (fifo_valid),
    .pop_ready_i (back_ready),
    .pop_data_o  (fifo_cmd)
  );

  // Back end: owns the cursor and the cell memories and registers the result.
  tcw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (fifo_valid),
    .cmd_ready_o  (back_ready),
    .cmd_i        (fifo_cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cell_char_o  (cell_char),
    .cell_colour_o(cell_colour),
    .cursor_col_o (cursor_col),
    .cursor_row_o (cursor_row),
    .status_o     (back_status)
  );

  assign m_axis_tdata = {4'b0000, cursor_row, cursor_col, cell_colour, cell_char};

`ifndef SYNTHESIS
  // The back end never takes a new command while it is still executing one.
  a_no_pop_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.busy |-> !(fifo_valid && back_ready))
    else $error("command popped while back end busy");

  // When the clear sweep ends, its result beat is presented.
  a_clear_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.clearing |=> (back_status.clearing || m_axis_tvalid))
    else $error("clear sweep ended without a result beat");

  // A classified command blocked by a full queue is held unchanged.
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_valid && !fifo_ready) |=> (front_valid && $stable(front_cmd)))
    else $error("front end dropped or changed a blocked command");

  // Whenever a result beat is valid, the reported cursor lies on the grid.
  a_cursor_on_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cursor_col <= COL_MAX && cursor_row <= ROW_MAX))
    else $error("cursor off the grid");
`endif

endmodule
